[rtl/core/softmax_argmax_classifier_head_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the classifier head
// Implication and next-cycle checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SOFTMAX_ARGMAX_CLASSIFIER_HEAD_TOP_DEFINES_SVH
`define SOFTMAX_ARGMAX_CLASSIFIER_HEAD_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SACH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define SACH_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SACH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SACH_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/core/sach_pkg.sv]
// ----------------------------------------------------------------------------
// Classifier head package
// Widths, codes, exp factor tables and controller/datapath command types.
// ----------------------------------------------------------------------------
package sach_pkg;

   localparam int MAX_CLASSES_DEF = 8;
   localparam int LABEL_COUNT     = 7;
   localparam int LOGIT_W         = 16;
   localparam int CONF_W          = 16;
   localparam int INDEX_W         = 3;
   localparam int STATUS_W        = 2;
   localparam int NUM_CLASSES_W   = 4;
   localparam int CFG_IDX_W       = 1;
   localparam int CFG_DATA_W      = 16;
   localparam int FACTOR_W        = 17;
   localparam int PROD_W          = 2 * FACTOR_W;
   localparam int DIV_STEPS       = CONF_W;
   localparam int DCNT_W          = $clog2(DIV_STEPS + 1);

   localparam logic [NUM_CLASSES_W-1:0] NUM_CLASSES_RST = NUM_CLASSES_W'(7);

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LOW      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOLABEL  = 2'd3;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] CSR_MIN_CONF    = 1'd0;
   localparam logic [CFG_IDX_W-1:0] CSR_NUM_CLASSES = 1'd1;

   typedef struct packed {
      logic load;       // take one word into the run
      logic finish;     // the word taken is the last of the run
      logic rd_start;   // rewind the read index and clear the sum
      logic rd_issue;   // read one stored logit into the exp pipe
      logic div_start;
      logic div_step;
      logic out_load;   // fill the result register
      logic clear_run;
   } cmd_type;

   typedef struct packed {
      logic mismatch;
      logic rd_done;
      logic pipe_empty;
      logic div_done;
      logic rsp_free;
   } sts_type;

   // exp(-n), integer part of the distance
   function automatic logic [FACTOR_W-1:0] exp_int(input logic [7:0] n);
      logic [FACTOR_W-1:0] f;
      case (n)
         8'd0:    f = 17'd65536;
         8'd1:    f = 17'd24109;
         8'd2:    f = 17'd8869;
         8'd3:    f = 17'd3263;
         8'd4:    f = 17'd1200;
         8'd5:    f = 17'd442;
         8'd6:    f = 17'd162;
         8'd7:    f = 17'd60;
         8'd8:    f = 17'd22;
         8'd9:    f = 17'd8;
         8'd10:   f = 17'd3;
         8'd11:   f = 17'd1;
         default: f = 17'd0;
      endcase
      return f;
   endfunction

   // exp(-k/16)
   function automatic logic [FACTOR_W-1:0] exp_hi(input logic [3:0] k);
      logic [FACTOR_W-1:0] f;
      case (k)
         4'd0:    f = 17'd65536;
         4'd1:    f = 17'd61565;
         4'd2:    f = 17'd57835;
         4'd3:    f = 17'd54331;
         4'd4:    f = 17'd51039;
         4'd5:    f = 17'd47947;
         4'd6:    f = 17'd45042;
         4'd7:    f = 17'd42314;
         4'd8:    f = 17'd39750;
         4'd9:    f = 17'd37341;
         4'd10:   f = 17'd35079;
         4'd11:   f = 17'd32954;
         4'd12:   f = 17'd30957;
         4'd13:   f = 17'd29081;
         4'd14:   f = 17'd27319;
         default: f = 17'd25664;
      endcase
      return f;
   endfunction

   // exp(-j/256)
   function automatic logic [FACTOR_W-1:0] exp_lo(input logic [3:0] j);
      logic [FACTOR_W-1:0] f;
      case (j)
         4'd0:    f = 17'd65536;
         4'd1:    f = 17'd65280;
         4'd2:    f = 17'd65026;
         4'd3:    f = 17'd64772;
         4'd4:    f = 17'd64520;
         4'd5:    f = 17'd64268;
         4'd6:    f = 17'd64018;
         4'd7:    f = 17'd63768;
         4'd8:    f = 17'd63520;
         4'd9:    f = 17'd63272;
         4'd10:   f = 17'd63025;
         4'd11:   f = 17'd62780;
         4'd12:   f = 17'd62535;
         4'd13:   f = 17'd62291;
         4'd14:   f = 17'd62048;
         default: f = 17'd61806;
      endcase
      return f;
   endfunction

endpackage

[rtl/core/sach_ifs.sv]
// ----------------------------------------------------------------------------
// Classifier head channels
// Valid/ready channels for logit words in and result words out.
// ----------------------------------------------------------------------------
interface sach_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sach_pkg::LOGIT_W-1:0] logit;
   logic                                last;

   modport source (output valid, output logit, output last, input ready);
   modport sink   (input valid, input logit, input last, output ready);
endinterface

interface sach_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [sach_pkg::INDEX_W-1:0]         best_index;
   logic [sach_pkg::CONF_W-1:0]          confidence;
   logic [sach_pkg::STATUS_W-1:0]        status;

   modport source (output valid, output best_index, output confidence, output status,
                   input ready);
   modport sink   (input valid, input best_index, input confidence, input status,
                   output ready);
endinterface

[rtl/core/sach_ctrl.sv]
// ----------------------------------------------------------------------------
// Classifier head controller
// Sequences load, exp pass, reciprocal divide and result hand-off.
// ----------------------------------------------------------------------------
`include "softmax_argmax_classifier_head_top_defines.svh"

module sach_ctrl (
   input  logic              clock,
   input  logic              reset,
   sach_req_if.sink          req,
   output sach_pkg::cmd_type cmd,
   input  sach_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_EXP,
      ST_DRAIN,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req.ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req.ready = 1'b1;
            if (req.valid) begin
               cmd.load = 1'b1;
               if (req.last) begin
                  cmd.finish   = 1'b1;
                  cmd.rd_start = 1'b1;
                  state_in     = sts.mismatch ? ST_DONE : ST_EXP;
               end
            end
         end
         ST_EXP: begin
            if (sts.rd_done) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.rd_issue = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (sts.pipe_empty) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_DONE: begin
            // wait for the result register to free up
            if (sts.rsp_free) begin
               cmd.out_load  = 1'b1;
               cmd.clear_run = 1'b1;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   `SACH_ASSERT_IMP(a_out_slot_free, clock, reset, cmd.out_load, sts.rsp_free, "result overwritten")
   `SACH_ASSERT_NXT(a_mismatch_skips, clock, reset, cmd.finish && sts.mismatch, state_ff == ST_DONE, "mismatch ran exp pass")
   `SACH_ASSERT_IMP(a_load_pipe_idle, clock, reset, req.ready, sts.pipe_empty, "word taken with exp pipe busy")

endmodule

[rtl/core/sach_datapath.sv]
// ----------------------------------------------------------------------------
// Classifier head datapath
// Logit store, running max, exp pipeline, sum, divider and result register.
// ----------------------------------------------------------------------------
`include "softmax_argmax_classifier_head_top_defines.svh"

module sach_datapath #(
   parameter int MAX_CLASSES = sach_pkg::MAX_CLASSES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [sach_pkg::CFG_IDX_W-1:0]         csr_index,
   input  logic [sach_pkg::CFG_DATA_W-1:0]        csr_wdata,
   input  logic signed [sach_pkg::LOGIT_W-1:0]    req_logit,
   input  sach_pkg::cmd_type                      cmd,
   output sach_pkg::sts_type                      sts,
   sach_rsp_if.source                             rsp
);

   localparam int AW    = $clog2(MAX_CLASSES);
   localparam int CW    = $clog2(MAX_CLASSES + 2);
   localparam int CMPW  = (CW > sach_pkg::NUM_CLASSES_W) ? CW : sach_pkg::NUM_CLASSES_W;
   localparam int SUM_W = sach_pkg::CONF_W + $clog2(MAX_CLASSES);
   localparam int RW    = SUM_W + 1;
   localparam int PW    = (AW > sach_pkg::INDEX_W) ? AW : sach_pkg::INDEX_W;
   localparam int LW    = sach_pkg::LOGIT_W;
   localparam int FW    = sach_pkg::FACTOR_W;
   localparam int PRW   = sach_pkg::PROD_W;
   localparam int CFW   = sach_pkg::CONF_W;

   localparam logic [CW-1:0]    MAX_C   = CW'(MAX_CLASSES);
   localparam logic [SUM_W-1:0] SUM_ONE = SUM_W'(1) << CFW;
   localparam logic [PRW-1:0]   ROUND   = PRW'(1) << (CFW - 1);

   // configuration
   logic [CFW-1:0]                      min_conf_ff;
   logic [sach_pkg::NUM_CLASSES_W-1:0]  num_classes_ff;

   // run state
   logic signed [LW-1:0] store_mem [MAX_CLASSES];
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic signed [LW-1:0] max_ff;
   logic [AW-1:0]        pos_ff;
   logic                 mis_ff;

   // exp pipeline
   logic [CW-1:0]        idx_ff;
   logic signed [LW-1:0] rd_data_ff;
   logic                 v1_ff;
   logic                 v2_ff;
   logic                 v3_ff;
   logic [LW-1:0]        diff;
   logic [PRW-1:0]       prod1_ff;
   logic [3:0]           j1_ff;
   logic [PRW-1:0]       rnd1;
   logic [PRW-1:0]       prod2_ff;
   logic [PRW-1:0]       rnd2;
   logic [FW-1:0]        term_raw;
   logic [CFW-1:0]       term;
   logic [SUM_W-1:0]     sum_ff;

   // divider
   logic [RW-1:0]                   rem_ff;
   logic [RW-1:0]                   shifted;
   logic                            ge;
   logic [CFW-1:0]                  quo_ff;
   logic [sach_pkg::DCNT_W-1:0]     dcnt_ff;
   logic [CFW-1:0]                  conf;

   // result register
   logic                              rsp_valid_ff;
   logic [sach_pkg::INDEX_W-1:0]      best_ff;
   logic [CFW-1:0]                    conf_ff;
   logic [sach_pkg::STATUS_W-1:0]     status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_conf_ff    <= '0;
         num_classes_ff <= sach_pkg::NUM_CLASSES_RST;
      end else if (csr_we) begin
         case (csr_index)
            sach_pkg::CSR_MIN_CONF:    min_conf_ff    <= csr_wdata;
            sach_pkg::CSR_NUM_CLASSES: num_classes_ff <= csr_wdata[sach_pkg::NUM_CLASSES_W-1:0];
            default: ;
         endcase
      end
   end

   // count saturates one past the capacity
   assign count_in = (count_ff <= MAX_C) ? count_ff + CW'(1) : count_ff;

   assign sts.mismatch = (num_classes_ff == '0) ||
                         (CMPW'(num_classes_ff) > CMPW'(MAX_CLASSES)) ||
                         (CMPW'(count_in) != CMPW'(num_classes_ff));

   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < MAX_C)) begin
         store_mem[count_ff[AW-1:0]] <= req_logit;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= store_mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_run) begin
         count_ff <= '0;
         max_ff   <= {1'b1, {(LW-1){1'b0}}};
         pos_ff   <= '0;
      end else if (cmd.load) begin
         if (count_ff < MAX_C) begin
            if ((count_ff == '0) || (req_logit > max_ff)) begin
               max_ff <= req_logit;
               pos_ff <= count_ff[AW-1:0];
            end
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         mis_ff <= sts.mismatch;
      end
   end

   // exp pass: read, factor product, lo factor product, accumulate
   assign diff     = LW'(max_ff - rd_data_ff);
   assign rnd1     = prod1_ff + ROUND;
   assign rnd2     = prod2_ff + ROUND;
   assign term_raw = rnd2[CFW+FW-1:CFW];
   assign term     = term_raw[FW-1] ? '1 : term_raw[CFW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
      end else begin
         if (cmd.rd_start) begin
            idx_ff <= '0;
         end else if (cmd.rd_issue) begin
            idx_ff <= idx_ff + CW'(1);
         end
         v1_ff <= cmd.rd_issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod1_ff <= PRW'(sach_pkg::exp_int(diff[LW-1:8])) * PRW'(sach_pkg::exp_hi(diff[7:4]));
      j1_ff    <= diff[3:0];
      prod2_ff <= PRW'(rnd1[CFW+FW-1:CFW]) * PRW'(sach_pkg::exp_lo(j1_ff));
      if (cmd.rd_start) begin
         sum_ff <= '0;
      end else if (v3_ff) begin
         sum_ff <= sum_ff + SUM_W'(term);
      end
   end

   assign sts.rd_done    = (idx_ff == count_ff);
   assign sts.pipe_empty = !(v1_ff || v2_ff || v3_ff);

   // restoring divide of 2^32 by the sum, one quotient bit a cycle
   assign shifted = {rem_ff[RW-2:0], 1'b0};
   assign ge      = (shifted >= {1'b0, sum_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= RW'(SUM_ONE);
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? shifted - {1'b0, sum_ff} : shifted;
         quo_ff <= {quo_ff[CFW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.div_start) begin
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + sach_pkg::DCNT_W'(1);
      end
   end

   assign sts.div_done = (dcnt_ff == sach_pkg::DCNT_W'(sach_pkg::DIV_STEPS));
   // a sum up to 2^16 gives a quotient of 2^16 or more: saturate
   assign conf = (sum_ff <= SUM_ONE) ? '1 : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (mis_ff) begin
            best_ff   <= '0;
            conf_ff   <= '0;
            status_ff <= sach_pkg::STATUS_MISMATCH;
         end else begin
            best_ff <= sach_pkg::INDEX_W'(pos_ff);
            conf_ff <= conf;
            if (conf < min_conf_ff) begin
               status_ff <= sach_pkg::STATUS_LOW;
            end else if (PW'(pos_ff) >= PW'(sach_pkg::LABEL_COUNT)) begin
               status_ff <= sach_pkg::STATUS_NOLABEL;
            end else begin
               status_ff <= sach_pkg::STATUS_OK;
            end
         end
      end
   end

   assign sts.rsp_free   = !rsp_valid_ff || rsp.ready;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.best_index = best_ff;
   assign rsp.confidence = conf_ff;
   assign rsp.status     = status_ff;

   `SACH_ASSERT_IMP(a_rd_in_run, clock, reset, cmd.rd_issue, idx_ff < count_ff, "read past run")
   `SACH_ASSERT_NXT(a_out_shown, clock, reset, cmd.out_load, rsp_valid_ff, "result not shown")
   `SACH_ASSERT_IMP(a_div_bound, clock, reset, cmd.div_step, !sts.div_done, "divider overrun")

endmodule

[rtl/core/softmax_argmax_classifier_head_top.sv]
// ----------------------------------------------------------------------------
// Softmax/argmax classifier head
// Logit words load one per cycle while the controller is in its load state;
// a run of N logits ends with one result word. The exp pass reads each
// stored logit once through a 3-stage multiply pipe; the reciprocal comes
// from a bit-serial divider. A count mismatch skips both and goes straight
// to the result hand-off. Next run loads while the result waits. Sync reset
// clears the run; min_confidence 0, num_classes 7.
// ----------------------------------------------------------------------------
module softmax_argmax_classifier_head_top #(
   parameter int MAX_CLASSES = sach_pkg::MAX_CLASSES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [sach_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [sach_pkg::CFG_DATA_W-1:0] csr_wdata,
   sach_req_if.sink                        req,
   sach_rsp_if.source                      rsp
);

   sach_pkg::cmd_type cmd;
   sach_pkg::sts_type sts;

   sach_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .cmd   (cmd),
      .sts   (sts)
   );

   sach_datapath #(
      .MAX_CLASSES (MAX_CLASSES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_logit (req.logit),
      .cmd       (cmd),
      .sts       (sts),
      .rsp       (rsp)
   );

endmodule
